[sv/tmts_pkg.sv]
// tmts_pkg: constants, op codes and rule record types for the tape machine step engine
// used by tmts_tape_mem, tmts_rule_mem and multi_tape_turing_machine_step
`default_nettype none
package tmts_pkg;
    localparam int NUM_TAPES  = 2;
    localparam int MAX_RULES  = 64;
    localparam int TAPE_CELLS = 1024;
    localparam int POS_W      = 10;
    localparam int TAPE_AW    = (NUM_TAPES > 1) ? $clog2(NUM_TAPES) : 1;
    localparam int TADDR_W    = TAPE_AW + POS_W;
    localparam int TAPE_DEPTH = NUM_TAPES * TAPE_CELLS;
    localparam int RULE_AW    = 6;
    localparam int RCNT_W     = 7;

    localparam logic [7:0] BLANK = 8'h5F;
    localparam logic [7:0] WILD  = 8'h2A;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_STEP   = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_STAY  = 2'd2;

    localparam logic [1:0] CFG_INITIAL = 2'd0;
    localparam logic [1:0] CFG_FINAL   = 2'd1;
    localparam logic [1:0] CFG_RCOUNT  = 2'd2;

    typedef struct packed {
        logic [7:0] old_sym;
        logic [7:0] new_sym;
        logic [1:0] dir;
    } part_t;

    typedef struct packed {
        logic [5:0] old_state;
        logic [5:0] new_state;
        part_t [NUM_TAPES-1:0] parts;
    } rule_t;
endpackage
`default_nettype wire

[sv/tmts_tape_mem.sv]
// tmts_tape_mem: tape cell memory, one write and one registered read per cycle
// depends on tmts_pkg
`default_nettype none
module tmts_tape_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [tmts_pkg::TADDR_W-1:0] waddr,
    input  wire logic [7:0]                  wdata,
    input  wire logic [tmts_pkg::TADDR_W-1:0] raddr,
    output logic [7:0]                       rdata
);
    logic [7:0] mem [tmts_pkg::TAPE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/tmts_rule_mem.sv]
// tmts_rule_mem: rule store, one record per rule, state pair and per-tape parts written apart
// depends on tmts_pkg
`default_nettype none
module tmts_rule_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [tmts_pkg::RULE_AW-1:0] waddr,
    input  wire logic [tmts_pkg::TAPE_AW-1:0] wtape,
    input  wire logic [5:0]                  wold_state,
    input  wire logic [5:0]                  wnew_state,
    input  tmts_pkg::part_t                  wpart,
    input  wire logic [tmts_pkg::RULE_AW-1:0] raddr,
    output tmts_pkg::rule_t                  rdata
);
    tmts_pkg::rule_t mem [tmts_pkg::MAX_RULES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr].old_state    <= wold_state;
            mem[waddr].new_state    <= wnew_state;
            mem[waddr].parts[wtape] <= wpart;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/multi_tape_turing_machine_step.sv]
// multi_tape_turing_machine_step: sequencer for a bounded multi-tape machine
// depends on tmts_pkg, tmts_tape_mem, tmts_rule_mem
//
// channel   direction  handshake          contents
// in        to block   in_valid/in_stall  op and rule/tape/symbol fields
// out       from block out_valid/out_stall status word
// cfg       to block   cfg_we             cfg_index, cfg_data
//
// most ops pass through a fetch and a done state; a step reads the head cell of each tape, scans
// the rules (rule_count capped at 64, one rule memory read a cycle), then writes back
// to each tape in turn
// clear and reset run a blanking pass over all tape cells
// a finished word waits in the output register while the next word is taken
`default_nettype none
module multi_tape_turing_machine_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        op,
    input  wire logic [5:0]        rule_index,
    input  wire logic [1:0]        tape_index,
    input  wire logic [5:0]        old_state,
    input  wire logic [5:0]        new_state,
    input  wire logic [7:0]        old_symbol,
    input  wire logic [7:0]        new_symbol,
    input  wire logic [1:0]        direction,
    input  wire logic [7:0]        input_symbol,
    input  wire logic signed [9:0] cell_position,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [5:0]             current_state_out,
    output logic                   halted,
    output logic                   in_final,
    output logic [31:0]            step_total,
    output logic signed [9:0]      head_zero_position,
    output logic [7:0]             symbol_out,
    output logic                   overrun
);
    localparam int TW = tmts_pkg::TAPE_AW;
    localparam int AW = tmts_pkg::TADDR_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HEAD_RD, S_HEAD_CAP, S_SCAN, S_EXEC, S_FETCH, S_DONE
    } state_t;

    state_t             state_reg;
    logic [2:0]         op_reg;
    logic [1:0]         ti_reg;
    logic [9:0]         pos_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [TW-1:0]      tsel_reg;
    logic [7:0]         sym_reg [tmts_pkg::NUM_TAPES];
    logic [tmts_pkg::RCNT_W-1:0] issue_reg;
    logic               inflight_reg;
    tmts_pkg::rule_t    rule_reg;
    logic [9:0]         head_reg [tmts_pkg::NUM_TAPES];
    logic [5:0]         mstate_reg;
    logic [31:0]        step_reg;
    logic               halted_reg;
    logic               overrun_reg;
    logic [9:0]         load_pos_reg;
    logic [5:0]         initial_reg;
    logic [63:0]        final_reg;
    logic [tmts_pkg::RCNT_W-1:0] rcount_reg;
    logic               out_valid_reg;
    logic [5:0]         out_state_reg;
    logic               out_halted_reg;
    logic               out_final_reg;
    logic [31:0]        out_step_reg;
    logic [9:0]         out_head_reg;
    logic [7:0]         out_sym_reg;
    logic               out_overrun_reg;

    logic               accept;
    logic               tm_we;
    logic [AW-1:0]      tm_waddr;
    logic [7:0]         tm_wdata;
    logic [AW-1:0]      tm_raddr;
    logic [7:0]         tm_rdata;
    logic               rm_we;
    tmts_pkg::rule_t    rm_rdata;
    tmts_pkg::part_t    load_part;
    tmts_pkg::part_t    exec_part;
    logic [tmts_pkg::RCNT_W-1:0] n_rules;
    logic               match;
    logic               tape_ok;
    logic signed [10:0] next_pos;
    logic [AW-1:0]      fetch_addr;
    logic [31:0]        step_inc;

    function automatic logic [AW-1:0] taddr(input logic [TW-1:0] t, input logic [9:0] p);
        taddr = {t, ~p[9], p[8:0]};
    endfunction

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign n_rules = (rcount_reg > tmts_pkg::RCNT_W'(tmts_pkg::MAX_RULES))
                   ? tmts_pkg::RCNT_W'(tmts_pkg::MAX_RULES) : rcount_reg;
    assign step_inc = (step_reg == 32'hFFFF_FFFF) ? step_reg : step_reg + 32'd1;

    assign load_part.old_sym = old_symbol;
    assign load_part.new_sym = new_symbol;
    assign load_part.dir     = (direction == 2'd3) ? tmts_pkg::DIR_STAY : direction;
    assign rm_we = accept && (op == tmts_pkg::OP_LOAD)
                && (32'(tape_index) < tmts_pkg::NUM_TAPES);

    assign exec_part = rule_reg.parts[tsel_reg];

    always_comb
    begin
        tape_ok = 1'b1;
        for (int t = 0; t < tmts_pkg::NUM_TAPES; t++)
        begin
            if (rm_rdata.parts[t].old_sym != tmts_pkg::WILD
                && rm_rdata.parts[t].old_sym != sym_reg[t])
            begin
                tape_ok = 1'b0;
            end
        end
        match = inflight_reg && (rm_rdata.old_state == mstate_reg) && tape_ok;
    end

    always_comb
    begin
        unique case (exec_part.dir)
            tmts_pkg::DIR_LEFT:  next_pos = 11'(signed'(head_reg[tsel_reg])) - 11'sd1;
            tmts_pkg::DIR_RIGHT: next_pos = 11'(signed'(head_reg[tsel_reg])) + 11'sd1;
            default:             next_pos = 11'(signed'(head_reg[tsel_reg]));
        endcase
    end

    assign fetch_addr = (op_reg == tmts_pkg::OP_READ)
                      ? taddr(ti_reg[TW-1:0], pos_reg) : taddr(TW'(0), head_reg[0]);

    always_comb
    begin
        tm_we    = 1'b0;
        tm_waddr = clr_addr_reg;
        tm_wdata = tmts_pkg::BLANK;
        tm_raddr = fetch_addr;
        unique case (state_reg)
            S_CLEAR:
            begin
                tm_we = 1'b1;
            end
            S_IDLE:
            begin
                tm_we    = accept && (op == tmts_pkg::OP_APPEND) && !load_pos_reg[9];
                tm_waddr = taddr(TW'(0), load_pos_reg);
                tm_wdata = input_symbol;
            end
            S_HEAD_RD, S_HEAD_CAP:
            begin
                tm_raddr = taddr(tsel_reg, head_reg[tsel_reg]);
            end
            S_EXEC:
            begin
                tm_we    = (exec_part.new_sym != tmts_pkg::WILD);
                tm_waddr = taddr(tsel_reg, head_reg[tsel_reg]);
                tm_wdata = exec_part.new_sym;
            end
            default:
            begin
                tm_raddr = fetch_addr;
            end
        endcase
    end

    tmts_tape_mem u_tape (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata),
        .raddr (tm_raddr),
        .rdata (tm_rdata)
    );

    tmts_rule_mem u_rules (
        .clk        (clk),
        .we         (rm_we),
        .waddr      (rule_index),
        .wtape      (tape_index[TW-1:0]),
        .wold_state (old_state),
        .wnew_state (new_state),
        .wpart      (load_part),
        .raddr      (issue_reg[tmts_pkg::RULE_AW-1:0]),
        .rdata      (rm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= tmts_pkg::OP_LOAD;
            ti_reg        <= '0;
            pos_reg       <= '0;
            clr_addr_reg  <= '0;
            tsel_reg      <= '0;
            issue_reg     <= '0;
            inflight_reg  <= 1'b0;
            rule_reg      <= '0;
            for (int t = 0; t < tmts_pkg::NUM_TAPES; t++)
            begin
                head_reg[t] <= '0;
                sym_reg[t]  <= '0;
            end
            mstate_reg    <= '0;
            step_reg      <= '0;
            halted_reg    <= 1'b0;
            overrun_reg   <= 1'b0;
            load_pos_reg  <= '0;
            initial_reg   <= '0;
            final_reg     <= '0;
            rcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_state_reg   <= '0;
            out_halted_reg  <= 1'b0;
            out_final_reg   <= 1'b0;
            out_step_reg    <= '0;
            out_head_reg    <= '0;
            out_sym_reg     <= '0;
            out_overrun_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tmts_pkg::CFG_INITIAL: initial_reg <= cfg_data[5:0];
                    tmts_pkg::CFG_FINAL:   final_reg   <= cfg_data;
                    tmts_pkg::CFG_RCOUNT:  rcount_reg  <= cfg_data[tmts_pkg::RCNT_W-1:0];
                    default:               ;
                endcase
            end
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(tmts_pkg::TAPE_DEPTH - 1))
                    begin
                        state_reg <= (op_reg == tmts_pkg::OP_CLEAR) ? S_FETCH : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op;
                        ti_reg    <= tape_index;
                        pos_reg   <= cell_position;
                        unique case (op)
                            tmts_pkg::OP_APPEND:
                            begin
                                if (load_pos_reg[9])
                                begin
                                    overrun_reg <= 1'b1;
                                    halted_reg  <= 1'b1;
                                end
                                else
                                begin
                                    load_pos_reg <= load_pos_reg + 10'd1;
                                end
                                state_reg <= S_FETCH;
                            end
                            tmts_pkg::OP_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                load_pos_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            tmts_pkg::OP_START:
                            begin
                                for (int t = 0; t < tmts_pkg::NUM_TAPES; t++)
                                begin
                                    head_reg[t] <= '0;
                                end
                                mstate_reg  <= initial_reg;
                                step_reg    <= '0;
                                halted_reg  <= 1'b0;
                                overrun_reg <= 1'b0;
                                state_reg   <= S_FETCH;
                            end
                            tmts_pkg::OP_STEP:
                            begin
                                if (!halted_reg && !final_reg[mstate_reg])
                                begin
                                    tsel_reg  <= '0;
                                    state_reg <= S_HEAD_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FETCH;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FETCH;
                            end
                        endcase
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CAP;
                end
                S_HEAD_CAP:
                begin
                    sym_reg[tsel_reg] <= tm_rdata;
                    if (32'(tsel_reg) == tmts_pkg::NUM_TAPES - 1)
                    begin
                        issue_reg    <= '0;
                        inflight_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        tsel_reg  <= tsel_reg + TW'(1);
                        state_reg <= S_HEAD_RD;
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        rule_reg     <= rm_rdata;
                        tsel_reg     <= '0;
                        inflight_reg <= 1'b0;
                        state_reg    <= S_EXEC;
                    end
                    else if (issue_reg < n_rules)
                    begin
                        issue_reg    <= issue_reg + 1'b1;
                        inflight_reg <= 1'b1;
                    end
                    else if (inflight_reg)
                    begin
                        inflight_reg <= 1'b0;
                    end
                    else
                    begin
                        halted_reg <= 1'b1;
                        step_reg   <= step_inc;
                        state_reg  <= S_FETCH;
                    end
                end
                S_EXEC:
                begin
                    if (next_pos[10] != next_pos[9])
                    begin
                        overrun_reg <= 1'b1;
                        halted_reg  <= 1'b1;
                    end
                    else
                    begin
                        head_reg[tsel_reg] <= next_pos[9:0];
                    end
                    if (32'(tsel_reg) == tmts_pkg::NUM_TAPES - 1)
                    begin
                        mstate_reg <= rule_reg.new_state;
                        step_reg   <= step_inc;
                        state_reg  <= S_FETCH;
                    end
                    else
                    begin
                        tsel_reg <= tsel_reg + TW'(1);
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                        out_state_reg   <= mstate_reg;
                        out_halted_reg  <= halted_reg;
                        out_final_reg   <= final_reg[mstate_reg];
                        out_step_reg    <= step_reg;
                        out_head_reg    <= head_reg[0];
                        out_overrun_reg <= overrun_reg;
                        if (op_reg == tmts_pkg::OP_READ
                            && 32'(ti_reg) >= tmts_pkg::NUM_TAPES)
                        begin
                            out_sym_reg <= tmts_pkg::BLANK;
                        end
                        else
                        begin
                            out_sym_reg <= tm_rdata;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign current_state_out  = out_state_reg;
    assign halted             = out_halted_reg;
    assign in_final           = out_final_reg;
    assign step_total         = out_step_reg;
    assign head_zero_position = out_head_reg;
    assign symbol_out         = out_sym_reg;
    assign overrun            = out_overrun_reg;
endmodule
`default_nettype wire
